[rtl/beacon_ssid_rewriter_top_macros.svh]
// assertion macros shared by the rtl
`ifndef BEACON_SSID_REWRITER_TOP_MACROS_SVH
`define BEACON_SSID_REWRITER_TOP_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define BSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsr assertion failed");

// next-cycle implication checked outside reset
`define BSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsr assertion failed");

`endif

[rtl/bsr_pkg.sv]
`timescale 1ns / 1ps
package bsr_pkg;

  localparam int unsigned MAX_SSID_BYTES = 32;
  localparam int unsigned SSID_CNT_W     = $clog2(MAX_SSID_BYTES + 1);
  localparam int unsigned SSID_IDX_W     = (MAX_SSID_BYTES > 1) ? $clog2(MAX_SSID_BYTES) : 1;
  localparam int unsigned SSID_VEC_W     = MAX_SSID_BYTES * 8;

  localparam logic [15:0] POS_SAT     = 16'hffff;
  localparam logic [16:0] SSID_OFFSET = 17'd37;
  localparam logic [7:0]  FC_BEACON   = 8'h80;

  typedef enum logic [2:0] {
    CFG_SSID_LENGTH = 3'd0,
    CFG_SSID_0_7    = 3'd1,
    CFG_SSID_8_15   = 3'd2,
    CFG_SSID_16_23  = 3'd3,
    CFG_SSID_24_31  = 3'd4
  } cfg_idx_e;

  // what one consumed input byte asks of the output side
  typedef struct packed {
    logic                  has_result;
    logic [7:0]            byte_val;
    logic                  byte_valid;
    logic                  end_flag;
    logic                  fwd;
    logic                  insert;
    logic [SSID_CNT_W-1:0] ins_cnt;
    logic                  ins_end;
    logic                  ins_fwd;
  } bsr_action_t;

  typedef struct packed {
    logic take_item;
    logic busy;
  } bsr_emit_status_t;

endpackage

[rtl/bsr_parser.sv]
`timescale 1ns / 1ps
module bsr_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          consume_i,
  input  logic [7:0]                    frame_byte_i,
  input  logic                          frame_end_i,
  input  logic [bsr_pkg::SSID_CNT_W-1:0] ssid_len_i,
  output bsr_pkg::bsr_action_t          act_o
);
  import bsr_pkg::*;

  logic [15:0] pos_q, pos_d;
  logic [15:0] rt_len_q, rt_len_d;
  logic        version_ok_q, version_ok_d;
  logic        is_beacon_q, is_beacon_d;
  logic        fc_ok_q, fc_ok_d;
  logic [7:0]  lead0_q, lead0_d;
  logic [7:0]  lead1_q, lead1_d;
  logic [7:0]  drop_q, drop_d;

  logic                  late;
  logic                  do_insert;
  logic                  dropping;
  logic [SSID_CNT_W-1:0] cnt;
  logic [15:0]           rt_new;

  always_comb begin
    late         = (pos_q == POS_SAT);
    dropping     = (drop_q != 8'd0);
    version_ok_d = version_ok_q;
    is_beacon_d  = is_beacon_q;
    fc_ok_d      = fc_ok_q;
    lead0_d      = lead0_q;
    lead1_d      = lead1_q;
    rt_new       = rt_len_q;

    if (!late) begin
      if (pos_q == 16'd0) begin
        version_ok_d = (frame_byte_i == 8'd0);
        lead0_d      = frame_byte_i;
      end else if (pos_q == 16'd1) begin
        lead1_d = frame_byte_i;
      end else if (pos_q == 16'd2) begin
        rt_new = {8'd0, frame_byte_i};
      end else if (pos_q == 16'd3) begin
        rt_new = {frame_byte_i, rt_len_q[7:0]};
        // zero-length radiotap: frame control overlaps the header
        if (rt_new == 16'd0) begin
          is_beacon_d = (lead0_q == FC_BEACON) && (lead1_q == 8'd0);
        end
      end else begin
        if (pos_q == rt_len_q) begin
          fc_ok_d = (frame_byte_i == FC_BEACON);
        end
        if ({1'b0, pos_q} == {1'b0, rt_len_q} + 17'd1) begin
          is_beacon_d = fc_ok_q && (frame_byte_i == 8'd0);
        end
      end
    end

    cnt = (ssid_len_i > SSID_CNT_W'(MAX_SSID_BYTES)) ? SSID_CNT_W'(MAX_SSID_BYTES)
                                                    : ssid_len_i;
    do_insert = !dropping && !late && (pos_q >= 16'd4) && is_beacon_d && version_ok_d
                && ({1'b0, pos_q} == {1'b0, rt_new} + SSID_OFFSET);

    drop_d = dropping ? (drop_q - 8'd1) : (do_insert ? frame_byte_i : drop_q);

    act_o.has_result = !dropping || frame_end_i;
    act_o.byte_valid = !dropping;
    act_o.byte_val   = dropping ? 8'd0 : (do_insert ? 8'(cnt) : frame_byte_i);
    act_o.insert     = do_insert && (cnt != '0);
    act_o.end_flag   = frame_end_i && !act_o.insert;
    act_o.fwd        = act_o.end_flag && is_beacon_d;
    act_o.ins_cnt    = cnt;
    act_o.ins_end    = frame_end_i;
    act_o.ins_fwd    = is_beacon_d;

    rt_len_d = late ? rt_len_q : rt_new;
    pos_d    = late ? pos_q : (pos_q + 16'd1);

    if (frame_end_i) begin
      pos_d        = 16'd0;
      rt_len_d     = 16'd0;
      version_ok_d = 1'b0;
      is_beacon_d  = 1'b0;
      fc_ok_d      = 1'b0;
      lead0_d      = 8'd0;
      lead1_d      = 8'd0;
      drop_d       = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= 16'd0;
      rt_len_q     <= 16'd0;
      version_ok_q <= 1'b0;
      is_beacon_q  <= 1'b0;
      fc_ok_q      <= 1'b0;
      lead0_q      <= 8'd0;
      lead1_q      <= 8'd0;
      drop_q       <= 8'd0;
    end else if (consume_i) begin
      pos_q        <= pos_d;
      rt_len_q     <= rt_len_d;
      version_ok_q <= version_ok_d;
      is_beacon_q  <= is_beacon_d;
      fc_ok_q      <= fc_ok_d;
      lead0_q      <= lead0_d;
      lead1_q      <= lead1_d;
      drop_q       <= drop_d;
    end
  end

endmodule

[rtl/bsr_emitter.sv]
`timescale 1ns / 1ps
module bsr_emitter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           consume_i,
  input  bsr_pkg::bsr_action_t           act_i,
  input  logic [bsr_pkg::SSID_VEC_W-1:0] ssid_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [7:0]                     out_byte_o,
  output logic                           out_byte_valid_o,
  output logic                           out_end_o,
  output logic                           forward_frame_o,
  output bsr_pkg::bsr_emit_status_t      status_o
);
  import bsr_pkg::*;

  logic                  out_valid_q, out_valid_d;
  logic [7:0]            byte_q, byte_d;
  logic                  byte_valid_q, byte_valid_d;
  logic                  end_q, end_d;
  logic                  fwd_q, fwd_d;
  logic [SSID_CNT_W-1:0] ins_left_q, ins_left_d;
  logic [SSID_IDX_W-1:0] ins_idx_q, ins_idx_d;
  logic                  ins_end_q, ins_end_d;
  logic                  ins_fwd_q, ins_fwd_d;

  logic ready;
  logic busy;
  logic last_ins;

  assign ready    = !out_valid_q || !out_stall_i;
  assign busy     = (ins_left_q != '0);
  assign last_ins = (ins_left_q == SSID_CNT_W'(1));

  assign status_o.take_item = ready && !busy;
  assign status_o.busy      = busy;

  always_comb begin
    out_valid_d  = out_valid_q;
    byte_d       = byte_q;
    byte_valid_d = byte_valid_q;
    end_d        = end_q;
    fwd_d        = fwd_q;
    ins_left_d   = ins_left_q;
    ins_idx_d    = ins_idx_q;
    ins_end_d    = ins_end_q;
    ins_fwd_d    = ins_fwd_q;

    if (ready) begin
      out_valid_d = 1'b0;
      if (busy) begin
        // replacement ssid bytes, one per transfer
        out_valid_d  = 1'b1;
        byte_d       = ssid_i[{ins_idx_q, 3'b000} +: 8];
        byte_valid_d = 1'b1;
        end_d        = ins_end_q && last_ins;
        fwd_d        = ins_end_q && last_ins && ins_fwd_q;
        ins_left_d   = ins_left_q - SSID_CNT_W'(1);
        ins_idx_d    = ins_idx_q + SSID_IDX_W'(1);
      end else if (consume_i && act_i.has_result) begin
        out_valid_d  = 1'b1;
        byte_d       = act_i.byte_val;
        byte_valid_d = act_i.byte_valid;
        end_d        = act_i.end_flag;
        fwd_d        = act_i.fwd;
        ins_left_d   = act_i.insert ? act_i.ins_cnt : '0;
        ins_idx_d    = '0;
        ins_end_d    = act_i.ins_end;
        ins_fwd_d    = act_i.ins_fwd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ins_left_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      ins_left_q  <= ins_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q       <= byte_d;
    byte_valid_q <= byte_valid_d;
    end_q        <= end_d;
    fwd_q        <= fwd_d;
    ins_idx_q    <= ins_idx_d;
    ins_end_q    <= ins_end_d;
    ins_fwd_q    <= ins_fwd_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = byte_q;
  assign out_byte_valid_o = byte_valid_q;
  assign out_end_o        = end_q;
  assign forward_frame_o  = fwd_q;

endmodule

[rtl/beacon_ssid_rewriter_top.sv]
`timescale 1ns / 1ps
// Beacon SSID rewriter: frame bytes go in one per transfer and come out one per cycle
// unless the output stalls, through an input register and then a result register. At the
// SSID length byte of a version 0 beacon the block emits the configured length and then
// the configured SSID bytes, one per cycle through the single result register unless the
// output stalls, and input is stalled while the replacement bytes (0 to 32) go out;
// original SSID bytes are swallowed without producing output. Every frame ends with one
// result flagged out_end, whose forward_frame says whether the frame is a beacon to keep;
// if the last byte was swallowed that result is a bare marker with out_byte_valid low.
// Write the configuration only while the block is idle; a write takes effect at once.
`include "beacon_ssid_rewriter_top_macros.svh"
module beacon_ssid_rewriter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_byte_valid_o,
  output logic        out_end_o,
  output logic        forward_frame_o
);
  import bsr_pkg::*;

  logic [5:0]        ssid_len_q;
  logic [3:0][63:0]  ssid_q;

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_end_q;

  logic              consume;
  logic              in_take;
  bsr_action_t       act;
  bsr_emit_status_t  emit_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssid_len_q <= 6'd0;
      ssid_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SSID_LENGTH: ssid_len_q <= cfg_wdata_i[5:0];
        CFG_SSID_0_7:    ssid_q[0]  <= cfg_wdata_i;
        CFG_SSID_8_15:   ssid_q[1]  <= cfg_wdata_i;
        CFG_SSID_16_23:  ssid_q[2]  <= cfg_wdata_i;
        CFG_SSID_24_31:  ssid_q[3]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign consume    = in_valid_q && emit_st.take_item;
  assign in_stall_o = in_valid_q && !consume;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= frame_byte_i;
      in_end_q  <= frame_end_i;
    end
  end

  bsr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .consume_i    (consume),
    .frame_byte_i (in_byte_q),
    .frame_end_i  (in_end_q),
    .ssid_len_i   (SSID_CNT_W'(ssid_len_q)),
    .act_o        (act)
  );

  bsr_emitter u_emitter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .consume_i        (consume),
    .act_i            (act),
    .ssid_i           (SSID_VEC_W'(ssid_q)),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .out_byte_o       (out_byte_o),
    .out_byte_valid_o (out_byte_valid_o),
    .out_end_o        (out_end_o),
    .forward_frame_o  (forward_frame_o),
    .status_o         (emit_st)
  );

  // no new byte is taken from the input register while ssid bytes are going out
  `BSR_ASSERT_IMP(a_no_take_while_inserting, emit_st.busy, !consume)
  // a bare end marker is only ever the frame's last result
  `BSR_ASSERT_IMP(a_bare_marker_ends, out_valid_o && !out_byte_valid_o, out_end_o)
  // forward flag only rides on the end result
  `BSR_ASSERT_IMP(a_fwd_on_end, out_valid_o && forward_frame_o, out_end_o)
  // an insertion always leaves a result in the output register
  `BSR_ASSERT_NEXT(a_insert_emits, consume && act.insert, out_valid_o && emit_st.busy)

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import bsr_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       has_byte;
    logic       last;
    logic       fwd;
  } rewrite_t;

  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  cfg_idx_e   cfg_index = CFG_SSID_LENGTH;
  logic [63:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] frame_byte = '0;
  logic       frame_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_end;
  logic       forward_frame;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;

  rewrite_t   rewrite_q[$];
  logic [7:0] frame_buf[$];

  // shadow of the configuration registers
  logic [5:0]  ssid_len_reg = '0;
  logic [63:0] ssid_word_reg[4] = '{default: '0};

  // shadow of the per-frame parser state
  logic [15:0] pos = '0;
  logic [15:0] hdr_len = '0;
  logic        ver_ok = 1'b0;
  logic        beacon = 1'b0;
  logic        fc_ok = 1'b0;
  logic [7:0]  lead0 = '0;
  logic [7:0]  lead1 = '0;
  logic [7:0]  drop_left = '0;

  beacon_ssid_rewriter_top u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .frame_byte_i     (frame_byte),
    .frame_end_i      (frame_end),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_byte_o       (out_byte),
    .out_byte_valid_o (out_byte_valid),
    .out_end_o        (out_end),
    .forward_frame_o  (forward_frame)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    rewrite_t want;
    rewrite_t got;
    got = '{out_byte, out_byte_valid, out_end, forward_frame};
    if (rst_n && out_valid && !out_stall) begin
      if (rewrite_q.size() == 0) begin
        mismatches++;
        $display("%0t: mismatch expected no transfer, %s", $time,
                 $sformatf("got byte=%02h byte_valid=%b end=%b fwd=%b",
                           got.value, got.has_byte, got.last, got.fwd));
      end else begin
        want = rewrite_q.pop_front();
        if (got.value !== want.value || got.has_byte !== want.has_byte ||
            got.last !== want.last || got.fwd !== want.fwd) begin
          mismatches++;
          $display("%0t: mismatch expected byte=%02h byte_valid=%b end=%b fwd=%b, %s",
                   $time, want.value, want.has_byte, want.last, want.fwd,
                   $sformatf("got byte=%02h byte_valid=%b end=%b fwd=%b",
                             got.value, got.has_byte, got.last, got.fwd));
        end
      end
    end
  end

  function automatic rewrite_t mk_result(input logic [7:0] value, input logic has_byte);
    rewrite_t res;
    res.value = value;
    res.has_byte = has_byte;
    res.last = 1'b0;
    res.fwd = 1'b0;
    return res;
  endfunction

  // works out the transfers caused by one accepted frame byte
  task automatic predict_rewrite(input logic [7:0] b, input logic last);
    rewrite_t    res[$];
    logic        late;
    int unsigned p;
    int unsigned r;
    int unsigned cnt;
    late = (pos == POS_SAT);
    p = pos;
    r = hdr_len;
    if (!late) begin
      if (p == 0) begin
        ver_ok = (b == 8'h00);
        lead0 = b;
      end else if (p == 1) begin
        lead1 = b;
      end else if (p == 2) begin
        hdr_len = {8'h00, b};
      end else if (p == 3) begin
        hdr_len = {b, hdr_len[7:0]};
        // header length zero: frame control overlaps the first two bytes
        if (hdr_len == 16'h0000)
          beacon = (lead0 == FC_BEACON) && (lead1 == 8'h00);
      end else begin
        if (p == r)
          fc_ok = (b == FC_BEACON);
        if (p == r + 1)
          beacon = fc_ok && (b == 8'h00);
      end
      r = hdr_len;
    end
    if (drop_left != 0) begin
      drop_left--;
    end else if (!late && p >= 4 && beacon && ver_ok && p == r + SSID_OFFSET) begin
      cnt = ssid_len_reg;
      if (cnt > MAX_SSID_BYTES)
        cnt = MAX_SSID_BYTES;
      res = {res, mk_result(8'(cnt), 1'b1)};
      for (int i = 0; i < cnt; i++)
        res = {res, mk_result(ssid_word_reg[i >> 3][(i & 7) * 8 +: 8], 1'b1)};
      drop_left = b;
    end else begin
      res = {res, mk_result(b, 1'b1)};
    end
    if (last) begin
      if (res.size() == 0)
        res = {res, mk_result(8'h00, 1'b0)};
      res[res.size() - 1].last = 1'b1;
      res[res.size() - 1].fwd = beacon;
      pos = '0;
      hdr_len = '0;
      ver_ok = 1'b0;
      beacon = 1'b0;
      fc_ok = 1'b0;
      lead0 = '0;
      lead1 = '0;
      drop_left = '0;
    end else if (pos != POS_SAT) begin
      pos++;
    end
    foreach (res[i])
      rewrite_q = {rewrite_q, res[i]};
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    frame_byte <= b;
    frame_end <= last;
    do
      @(posedge clk);
    while (in_stall);
    predict_rewrite(b, last);
    @(negedge clk);
  endtask

  task automatic send_frame(input int pause_at);
    foreach (frame_buf[i]) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
      if (i == pause_at)
        drain();
    end
  endtask

  // sender holds off until every expected transfer is out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (rewrite_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    case (idx)
      CFG_SSID_LENGTH: ssid_len_reg = data[5:0];
      CFG_SSID_0_7:    ssid_word_reg[0] = data;
      CFG_SSID_8_15:   ssid_word_reg[1] = data;
      CFG_SSID_16_23:  ssid_word_reg[2] = data;
      CFG_SSID_24_31:  ssid_word_reg[3] = data;
      default: ;
    endcase
  endtask

  task automatic write_ssid(input logic [63:0] len_word, input logic [63:0] w0,
                            input logic [63:0] w1, input logic [63:0] w2,
                            input logic [63:0] w3);
    put_reg(CFG_SSID_LENGTH, len_word);
    put_reg(CFG_SSID_0_7, w0);
    put_reg(CFG_SSID_8_15, w1);
    put_reg(CFG_SSID_16_23, w2);
    put_reg(CFG_SSID_24_31, w3);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // radiotap header, frame control, fixed fields, ssid element, tail
  task automatic build_beacon(input logic [7:0] ver, input int unsigned rlen,
                              input logic [7:0] fc0, input logic [7:0] fc1,
                              input logic [7:0] old_len, input int unsigned tail);
    frame_buf.delete();
    frame_buf = {frame_buf, ver};
    frame_buf = {frame_buf, 8'($urandom)};
    frame_buf = {frame_buf, rlen[7:0]};
    frame_buf = {frame_buf, rlen[15:8]};
    while (frame_buf.size() < rlen)
      frame_buf = {frame_buf, 8'($urandom)};
    frame_buf = {frame_buf, fc0};
    frame_buf = {frame_buf, fc1};
    while (frame_buf.size() < rlen + SSID_OFFSET)
      frame_buf = {frame_buf, 8'($urandom)};
    frame_buf = {frame_buf, old_len};
    repeat (old_len) frame_buf = {frame_buf, 8'($urandom)};
    repeat (tail) frame_buf = {frame_buf, 8'($urandom)};
  endtask

  task automatic cut_frame(input int unsigned keep);
    while (frame_buf.size() > keep)
      frame_buf.delete(frame_buf.size() - 1);
  endtask

  // length zero from reset, and the last byte falls among the dropped ssid bytes
  task automatic test_reset_config();
    build_beacon(8'h00, 4, FC_BEACON, 8'h00, 8'd2, 0);
    send_frame(-1);
    drain();
  endtask

  task automatic test_short_frames();
    frame_buf = '{8'hff};
    send_frame(-1);
    frame_buf = '{8'h00, 8'hff};
    send_frame(-1);
    // header length zero, frame control sits in the version bytes
    frame_buf = '{FC_BEACON, 8'h00, 8'h00, 8'h00};
    send_frame(-1);
    // ends on the second frame control byte
    build_beacon(8'h00, 4, FC_BEACON, 8'h00, 8'd2, 0);
    cut_frame(6);
    send_frame(-1);
    drain();
  endtask

  task automatic test_full_ssid();
    // oversized length saturates, junk above the field is ignored
    write_ssid({58'h2aa_aaaa_aaaa_aaaa, 6'd63}, 64'hffff_ffff_ffff_ffff,
               64'h0706_0504_0302_0100, 64'h8899_aabb_ccdd_eeff, 64'h0000_0000_0000_0000);
    build_beacon(8'h00, 4, FC_BEACON, 8'h00, 8'd0, 1);
    // hold off right after the ssid length byte
    send_frame(4 + SSID_OFFSET);
    drain();
  endtask

  task automatic build_random_frame();
    int unsigned kind;
    kind = $urandom_range(3);
    if (kind == 0) begin
      frame_buf.delete();
      repeat ($urandom_range(1, 8)) frame_buf = {frame_buf, 8'($urandom)};
    end else begin
      build_beacon((kind == 1) ? 8'h01 : 8'h00, $urandom_range(4, 6),
                   ($urandom_range(3) != 0) ? FC_BEACON : 8'($urandom),
                   ($urandom_range(3) != 0) ? 8'h00 : 8'($urandom), 8'd0, 0);
      cut_frame($urandom_range(1, 10));
    end
  endtask

  task automatic test_random_phase(input int unsigned idle, input int unsigned stall);
    int unsigned sent;
    logic [63:0] len_word;
    idle_pct = idle;
    stall_pct = stall;
    case ($urandom_range(3))
      0: len_word = 64'd0;
      1: len_word = 64'd32;
      2: len_word = rand64() | 64'h3f;
      default: len_word = rand64();
    endcase
    write_ssid(len_word, rand64(), rand64(), rand64(), rand64());
    sent = 0;
    while (sent < 12) begin
      build_random_frame();
      send_frame(-1);
      sent += frame_buf.size();
    end
    drain();
  endtask

  initial begin
    @(negedge clk);
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_pct = 0;
    stall_pct = 0;
    test_reset_config();
    test_short_frames();
    stall_pct = 54;
    test_full_ssid();
    test_random_phase(54, 0);
    test_random_phase(31, 31);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/bsr_pkg.sv
rtl/bsr_parser.sv
rtl/bsr_emitter.sv
rtl/beacon_ssid_rewriter_top.sv
bench/tb_top.sv
